### hw/rtl/lef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lef_pkg: shared types and constants of the Laplacian edge filter
// Pixel and column types, field widths, register defaults and the
// 3x3 Laplacian kernel evaluated from per-column channel sums.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int COL_W         = 10;
  localparam int ROW_W         = 12;
  localparam int FW_W          = 11;
  localparam int FH_W          = 13;
  localparam int CSUM_W        = 10;   // sum of three channel bytes
  localparam int TOT_W         = 12;   // sum of nine channel bytes
  localparam int CH_MAX        = 255;
  localparam int MIN_DIM       = 3;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int FW_RESET      = 640;
  localparam int FH_RESET      = 480;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = FH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: previous-previous row, previous row, current row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Per-channel column sums, index 0 = blue, 2 = red.
  typedef logic [2:0][CSUM_W-1:0] csum_t;

  // 8*center - neighbors == 9*center - sum of all nine, saturated to 0..255.
  function automatic pix_t lap_pix(input csum_t sl, input csum_t sc, input csum_t sr,
                                   input pix_t ctr);
    pix_t                    res;
    logic [TOT_W-1:0]        tot;
    logic [TOT_W-1:0]        nine;
    logic signed [TOT_W:0]   acc;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      tot  = TOT_W'(sl[ch]) + TOT_W'(sc[ch]) + TOT_W'(sr[ch]);
      nine = (TOT_W'(ctr[ch*CH_W +: CH_W]) << 3) + TOT_W'(ctr[ch*CH_W +: CH_W]);
      acc  = $signed({1'b0, nine}) - $signed({1'b0, tot});
      if (acc < 0) begin
        res[ch*CH_W +: CH_W] = '0;
      end else if (acc > CH_MAX) begin
        res[ch*CH_W +: CH_W] = '1;
      end else begin
        res[ch*CH_W +: CH_W] = acc[CH_W-1:0];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lef_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lef_pix_if: input pixel channel
// Valid/ready handshake carrying one RGB pixel word.
// ----------------------------------------------------------------------------
interface lef_pix_if import lef_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/lef_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lef_res_if: result channel
// Valid/ready handshake carrying one filtered pixel word with its position.
// ----------------------------------------------------------------------------
interface lef_res_if import lef_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic             run_last;

  modport source (output valid, output out_col, output out_row, output red_out,
                  output green_out, output blue_out, output run_last, input ready);
  modport sink   (input valid, input out_col, input out_row, input red_out,
                  input green_out, input blue_out, input run_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/lef_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lef_cell: one column of the 3x3 window
// Holds three pixels, takes its neighbor's column on shift and presents
// per-channel column sums for the kernel.
// ----------------------------------------------------------------------------
module lef_cell import lef_pkg::*; (
  input  wire logic  clk,
  input  wire logic  shift_en,
  input  wire col_t  col_in,
  output col_t       col_out,
  output csum_t      col_sum
);

  col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      col_sum[ch] = CSUM_W'(col_r.top[ch*CH_W +: CH_W]) +
                    CSUM_W'(col_r.mid[ch*CH_W +: CH_W]) +
                    CSUM_W'(col_r.bot[ch*CH_W +: CH_W]);
    end
  end

  assign col_out = col_r;

endmodule
`default_nettype wire

### hw/rtl/laplacian_edge_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_edge_filter: streaming 3x3 Laplacian on RGB raster pixels
// Throughput: one pixel per clock while the receiver is ready and each pixel
//   makes one word; a pixel making more holds the input (single output reg).
// Reset (sync, rst_n low): counters, pipeline valids cleared, size 640x480.
//   Line store is not cleared; only rows 0 and 1 read unwritten entries.
// ----------------------------------------------------------------------------
module laplacian_edge_filter import lef_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lef_pix_if.sink                    in_pix,
  lef_res_if.source                  out_res
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int MW_W = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (MW_W > FW_W) ? MW_W : FW_W;

  // Which result words a pixel still owes, in emission order LSB first.
  typedef struct packed {
    logic row_last;   // zero word of the last row at (x, y)
    logic row_end;    // zero right-border word at (x, y-1)
    logic lap;        // kernel word at (x-1, y-1)
    logic first_row;  // zero word of row 0
  } emit_t;

  // ---------------- configuration ----------------
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [WW-1:0]   fw_ext;
  logic [WW-1:0]   w_cl;
  logic [FH_W-1:0] h_cl;

  always_comb begin
    fw_ext = WW'(fw_r);
    if (fw_ext < WW'(MIN_DIM)) begin
      w_cl = WW'(MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = fw_ext;
    end
    if (fh_r < FH_W'(MIN_DIM)) begin
      h_cl = FH_W'(MIN_DIM);
    end else if (fh_r > FH_W'(MAX_HEIGHT)) begin
      h_cl = FH_W'(MAX_HEIGHT);
    end else begin
      h_cl = fh_r;
    end
  end

  // ---------------- raster position, stage A ----------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW:0]      x_inc;
  logic [FH_W-1:0]  y_inc;
  logic             row_done;
  logic             frame_done;
  logic             row_ge2;
  emit_t            emit_a;
  logic             inner_a;
  logic             in_fire;
  logic             in_ready;

  always_comb begin
    x_inc      = (WW+1)'(col_r) + (WW+1)'(1);
    y_inc      = FH_W'(row_r) + FH_W'(1);
    row_done   = x_inc >= (WW+1)'(w_cl);
    frame_done = y_inc >= h_cl;
    row_ge2    = row_r >= ROW_W'(2);

    emit_a.first_row = (row_r == '0);
    emit_a.lap       = row_ge2 && (col_r != '0);
    emit_a.row_end   = row_ge2 && row_done;
    emit_a.row_last  = (row_r != '0) && frame_done;

    // center (x-1, y-1) is interior
    inner_a = (col_r >= COL_W'(2)) && (x_inc <= (WW+1)'(w_cl)) &&
              row_ge2 && (y_inc <= h_cl);

    if (row_done) begin
      col_nxt = '0;
      row_nxt = frame_done ? '0 : y_inc[ROW_W-1:0];
    end else begin
      col_nxt = x_inc[COL_W-1:0];
      row_nxt = row_r;
    end
  end

  // ---------------- stage B: line store read data ----------------
  logic                 b_valid_r;
  pix_t                 b_px_r;
  logic [COL_W-1:0]     b_col_r;
  logic [ROW_W-1:0]     b_row_r;
  emit_t                b_emit_r;
  logic                 b_inner_r;
  logic                 b_fire;

  // Entry x holds {row y-2, row y-1} of column x.
  logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]   mem_q_r;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;

  assign rd_addr = AW'(col_r);
  assign wr_addr = AW'(b_col_r);

  // Read-modify-write: read on accept, write back as stage B advances.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_q_r <= line_mem[rd_addr];
    end
    if (b_fire) begin
      line_mem[wr_addr] <= {mem_q_r[PIX_W-1:0], b_px_r};
    end
  end

  // ---------------- window: chain of column cells ----------------
  col_t  col_w [4];
  csum_t sum_w [3];

  assign col_w[3] = {mem_q_r, b_px_r};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    lef_cell u_cell (
      .clk      (clk),
      .shift_en (b_fire),
      .col_in   (col_w[i+1]),
      .col_out  (col_w[i]),
      .col_sum  (sum_w[i])
    );
  end

  // ---------------- stage C: result expansion ----------------
  logic             c_valid_r;
  emit_t            c_emit_r;
  logic [COL_W-1:0] c_col_r;
  logic [ROW_W-1:0] c_row_r;
  logic             c_inner_r;
  logic             c_done;
  logic             c_ready;
  emit_t            sel;
  emit_t            rest;
  logic [COL_W-1:0] o_col;
  logic [ROW_W-1:0] o_row;
  pix_t             o_pix;
  pix_t             lap_val;
  logic             out_free;
  logic             out_load;

  assign lap_val = lap_pix(sum_w[0], sum_w[1], sum_w[2], col_w[1].mid);

  always_comb begin
    sel   = '0;
    o_col = c_col_r;
    o_row = c_row_r;
    o_pix = '0;
    priority if (c_emit_r.first_row) begin
      sel.first_row = 1'b1;
    end else if (c_emit_r.lap) begin
      sel.lap = 1'b1;
      o_col   = c_col_r - COL_W'(1);
      o_row   = c_row_r - ROW_W'(1);
      o_pix   = c_inner_r ? lap_val : '0;
    end else if (c_emit_r.row_end) begin
      sel.row_end = 1'b1;
      o_row       = c_row_r - ROW_W'(1);
    end else if (c_emit_r.row_last) begin
      sel.row_last = 1'b1;
    end else begin
      sel = '0;
    end
    rest = emit_t'(c_emit_r & ~sel);
  end

  logic             out_valid_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  pix_t             out_pix_r;
  logic             out_last_r;

  assign out_free = !out_valid_r || out_res.ready;
  assign out_load = c_valid_r && (c_emit_r != '0) && out_free;
  assign c_done   = c_valid_r && ((c_emit_r == '0) || (out_free && (rest == '0)));
  assign c_ready  = !c_valid_r || c_done;
  assign b_fire   = b_valid_r && c_ready;
  assign in_ready = !b_valid_r || c_ready;
  assign in_fire  = in_pix.valid && in_ready;

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FW_W'(FW_RESET);
      fh_r        <= FH_W'(FH_RESET);
      col_r       <= '0;
      row_r       <= '0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      c_emit_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_FRAME_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT: fh_r <= cfg_data[FH_W-1:0];
          default:          fw_r <= fw_r;
        endcase
      end
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire) begin
        c_valid_r <= 1'b1;
        c_emit_r  <= b_emit_r;
      end else if (c_done) begin
        c_valid_r <= 1'b0;
        c_emit_r  <= '0;
      end else if (out_load) begin
        c_emit_r  <= rest;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_px_r    <= {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
      b_col_r   <= col_r;
      b_row_r   <= row_r;
      b_emit_r  <= emit_a;
      b_inner_r <= inner_a;
    end
    if (b_fire) begin
      c_col_r   <= b_col_r;
      c_row_r   <= b_row_r;
      c_inner_r <= b_inner_r;
    end
    if (out_load) begin
      out_col_r  <= o_col;
      out_row_r  <= o_row;
      out_pix_r  <= o_pix;
      out_last_r <= (rest == '0);
    end
  end

  assign in_pix.ready      = in_ready;
  assign out_res.valid     = out_valid_r;
  assign out_res.out_col   = out_col_r;
  assign out_res.out_row   = out_row_r;
  assign out_res.red_out   = out_pix_r[3*CH_W-1:2*CH_W];
  assign out_res.green_out = out_pix_r[2*CH_W-1:CH_W];
  assign out_res.blue_out  = out_pix_r[CH_W-1:0];
  assign out_res.run_last  = out_last_r;

`ifndef ASSERT_OFF
  // row 0 words come alone
  a_first_row_alone: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_emit_r.first_row |-> !(c_emit_r.lap || c_emit_r.row_end ||
                                          c_emit_r.row_last))
    else $error("row 0 pixel owes extra words");

  // kernel words only for rows >= 2, columns >= 1
  a_lap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && c_emit_r.lap |-> (c_row_r >= ROW_W'(2)) && (c_col_r != '0))
    else $error("kernel word at invalid position");

  // an accepted pixel occupies stage B next cycle
  a_accept_b: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> b_valid_r)
    else $error("accepted pixel lost before stage B");

  // a new output word only comes from a pending stage C item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(c_valid_r))
    else $error("output word without source");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming Laplacian edge filter
// Streams RGB raster frames of many sizes through the filter and checks
// every result word against a cycle-free model of the filter kept in a
// scoreboard. Covers saturation, border zeros, clamped sizes, size changes
// in mid-frame, random valid/ready gaps, and widths and heights above range.
// ----------------------------------------------------------------------------
module tb_top;
  import lef_pkg::*;

  // One expected or observed result word, laid out like the result port.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pix_t             pix;   // {red, green, blue}
    logic             last;
  } res_word_t;

  // Filter model: own line stores, window, counters and size registers.
  // note_pixel() queues the result words that one accepted pixel causes;
  // check_result() compares an observed word with the oldest queued one.
  class edge_scoreboard;
    pix_t             line_top [MAX_WIDTH_DEF];   // row y-2
    pix_t             line_mid [MAX_WIDTH_DEF];   // row y-1
    pix_t             win [3][3];                 // [row][col], col 2 newest
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    res_word_t        expected_q [$];
    int unsigned      n_errors;

    function new();
      col        = '0;
      row        = '0;
      width_reg  = FW_W'(FW_RESET);
      height_reg = FH_W'(FH_RESET);
      n_errors   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
        CFG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (32'(width_reg) < MIN_DIM) return MIN_DIM;
      if (32'(width_reg) > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (32'(height_reg) < MIN_DIM) return MIN_DIM;
      if (32'(height_reg) > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function bit at_frame_start();
      return (col == '0) && (row == '0);
    endfunction

    // 8 * center minus the eight neighbors, per channel, clipped to a byte.
    function pix_t laplace();
      pix_t res;
      int   acc;
      res = '0;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 8 * int'(win[1][1][ch*CH_W +: CH_W]);
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            if (r != 1 || c != 1) acc -= int'(win[r][c][ch*CH_W +: CH_W]);
        if (acc < 0) acc = 0;
        if (acc > CH_MAX) acc = CH_MAX;
        res[ch*CH_W +: CH_W] = acc[CH_W-1:0];
      end
      return res;
    endfunction

    function void push_word(int unsigned c, int unsigned r, pix_t v);
      res_word_t wd;
      wd.col  = COL_W'(c);
      wd.row  = ROW_W'(r);
      wd.pix  = v;
      wd.last = 1'b0;
      expected_q.push_back(wd);
    endfunction

    function void note_pixel(pix_t px);
      int unsigned w, h, x, y, cx, cy, n_before;
      pix_t        top, mid, v;
      w        = eff_width();
      h        = eff_height();
      x        = 32'(col);
      y        = 32'(row);
      top      = line_top[COL_W'(x)];
      mid      = line_mid[COL_W'(x)];
      n_before = expected_q.size();
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2]   = top;
      win[1][2]   = mid;
      win[2][2]   = px;
      line_top[COL_W'(x)] = mid;
      line_mid[COL_W'(x)] = px;

      if (y == 0) begin
        push_word(x, 0, '0);
      end else begin
        if (y >= 2) begin
          // previous row, one column behind
          if (x >= 1) begin
            cx = x - 1;
            cy = y - 1;
            v  = '0;
            if (cx >= 1 && cx + 2 <= w && cy >= 1 && cy + 2 <= h) v = laplace();
            push_word(cx, cy, v);
          end
          // right border of the previous row closes it
          if (x + 1 >= w) push_word(x, y - 1, '0);
        end
        // last row goes out as it arrives
        if (y + 1 >= h) push_word(x, y, '0);
      end
      if (expected_q.size() > n_before) expected_q[expected_q.size()-1].last = 1'b1;

      if (x + 1 >= w) begin
        col = '0;
        row = (y + 1 >= h) ? '0 : ROW_W'(y + 1);
      end else begin
        col = COL_W'(x + 1);
      end
    endfunction

    function void field_check(string name, res_word_t want, logic [31:0] want_v,
                              logic [31:0] got_v);
      if (got_v !== want_v) begin
        n_errors++;
        $display("%0t ns: %s at (%0d,%0d): expected %0d, actual %0d",
                 $time, name, want.col, want.row, want_v, got_v);
      end
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t ns: result word with none pending: expected none, actual (%0d,%0d) %h",
                 $time, got.col, got.row, got.pix);
        return;
      end
      want = expected_q.pop_front();
      field_check("out_col",   want, 32'(want.col), 32'(got.col));
      field_check("out_row",   want, 32'(want.row), 32'(got.row));
      field_check("red_out",   want, 32'(want.pix[2*CH_W +: CH_W]),
                  32'(got.pix[2*CH_W +: CH_W]));
      field_check("green_out", want, 32'(want.pix[CH_W +: CH_W]),
                  32'(got.pix[CH_W +: CH_W]));
      field_check("blue_out",  want, 32'(want.pix[0 +: CH_W]),
                  32'(got.pix[0 +: CH_W]));
      field_check("run_last",  want, 32'(want.last), 32'(got.last));
    endfunction
  endclass

  localparam int DRAIN_GAP = 8;   // cycles past the last result before a cfg write

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lef_pix_if pix ();
  lef_res_if res ();

  laplacian_edge_filter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_pix   (pix),
    .out_res  (res)
  );

  edge_scoreboard sb = new();

  int in_idle_pct  = 17;   // sender gap chance per cycle, percent
  int out_idle_pct = 64;   // receiver stall chance per cycle, percent
  int n_sent       = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: ready changes on the falling edge only.
  initial res.ready = 1'b0;
  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Result monitor: a word moves at a rising edge with valid and ready high.
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready)
      sb.check_result(res_word_t'({res.out_col, res.out_row, res.red_out,
                                   res.green_out, res.blue_out, res.run_last}));
  end

  // Sends one pixel word. Entered and left at a falling edge; valid stays
  // high on exit so back-to-back words need no extra assignment.
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < in_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid    <= 1'b1;
    pix.red_in   <= px[2*CH_W +: CH_W];
    pix.green_in <= px[CH_W +: CH_W];
    pix.blue_in  <= px[0 +: CH_W];
    do @(posedge clk); while (!pix.ready);
    sb.note_pixel(px);
    n_sent++;
    @(negedge clk);
  endtask

  // Holds the input off until every pending result word is out, then lets
  // the pipeline settle (row-1 pixels cause no word but are still in flight).
  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Writes both size registers, one per cycle. Only called while idle.
  task automatic set_size(input int unsigned w_val, input int unsigned h_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w_val);
    sb.write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_val));
    @(negedge clk);
    cfg_idx  <= CFG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h_val);
    sb.write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_val));
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Sends pixels until the frame wraps back to its origin.
  //   mode 0: random bytes (mostly saturating results)
  //   mode 1: smooth area around a base color (mid-range results)
  //   mode 2: channels at 0 or 255 only
  // A broken frame stops once at a random pixel, drains, and rewrites the
  // sizes mid-frame. Width only shrinks there, so the line stores never
  // hand an unwritten entry to an interior result.
  task automatic send_frame(input int mode, input bit broken);
    pix_t        base, px;
    int          v;
    int unsigned cut, k;
    base = PIX_W'($urandom);
    cut  = broken ? $urandom_range(1, sb.eff_width() * sb.eff_height() - 1) : 0;
    k    = 0;
    do begin
      case (mode)
        0: px = PIX_W'($urandom);
        1: begin
          for (int ch = 0; ch < 3; ch++) begin
            v = int'(base[ch*CH_W +: CH_W]) + int'($urandom_range(12)) - 6;
            if (v < 0) v = 0;
            if (v > CH_MAX) v = CH_MAX;
            px[ch*CH_W +: CH_W] = v[CH_W-1:0];
          end
        end
        default: begin
          for (int ch = 0; ch < 3; ch++)
            px[ch*CH_W +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
      endcase
      send_pixel(px);
      k++;
      if (k == cut && !sb.at_frame_start()) begin
        // sender holds off here until every pending word has arrived
        wait_drained();
        set_size($urandom_range(0, sb.eff_width()), $urandom_range(0, sb.eff_height() + 3));
      end
    end while (!sb.at_frame_start());
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned target;
    pix_t        ring_px;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_FRAME_WIDTH;
    cfg_data     = '0;
    pix.valid    = 1'b0;
    pix.red_in   = '0;
    pix.green_in = '0;
    pix.blue_in  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: 3x3 frames, one interior pixel each ----
    // Frame A: red saturates high, green low, blue lands at 8*100 - 8*90 = 80.
    set_size(3, 3);
    for (int k = 0; k < 9; k++)
      send_pixel((k == 4) ? {8'd255, 8'd0, 8'd100} : {8'd0, 8'd255, 8'd90});
    // Frame B: sizes below range clamp to 3x3; red low, green high, blue mixed.
    wait_drained();
    set_size(0, 1);
    for (int k = 0; k < 9; k++) begin
      ring_px = {8'd255, 8'd0, 8'($urandom)};
      send_pixel((k == 4) ? {8'd0, 8'd255, 8'd128} : ring_px);
    end

    // ---- random frames, sender gaps light / receiver stalls heavy ----
    frame_no = 0;
    target   = n_sent + 60;
    while (n_sent < target) begin
      wait_drained();
      set_size(($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12),
               ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7));
      send_frame($urandom_range(2), (frame_no == 0) || ($urandom_range(3) == 0));
      frame_no++;
    end

    // ---- same again with the gaps swapped ----
    in_idle_pct  = 64;
    out_idle_pct = 17;
    target       = n_sent + 60;
    while (n_sent < target) begin
      wait_drained();
      set_size(($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12),
               ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7));
      send_frame($urandom_range(2), $urandom_range(3) == 0);
    end

    // ---- full rate: sizes above range clamp, frames cut short by a shrink ----
    in_idle_pct  = 0;
    out_idle_pct = 0;
    wait_drained();
    set_size(2047, 3);
    repeat (12) send_pixel(PIX_W'($urandom));
    wait_drained();
    set_size(3, 3);
    while (!sb.at_frame_start()) send_pixel(PIX_W'($urandom));
    wait_drained();
    set_size(3, 8191);
    repeat (15) send_pixel(PIX_W'($urandom));
    wait_drained();
    set_size(3, 3);
    while (!sb.at_frame_start()) send_pixel(PIX_W'($urandom));

    // ---- wind down: everything out, then a few quiet cycles ----
    wait_drained();
    repeat (4 * DRAIN_GAP) @(negedge clk);
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
